// ----- src/pesw_pkg.sv -----
// Shared constants, opcodes and control types of the polygon edge walker.
`default_nettype none
package pesw_pkg;

  localparam int ROWS_DEF = 64;   // default row capacity
  localparam int QW       = 24;   // quotient bits of the slope divide
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int RC_W     = 7;    // row_count register width

  localparam logic [ADDR_W-1:0] ADDR_ROW_COUNT = 3'd0;
  localparam logic [RC_W-1:0]   ROW_COUNT_RST  = 7'd64;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_LINE  = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic div_step;
    logic mul1;
    logic mul2;
    logic acc_init;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic edge_due;
    logic skip;
    logic div_done;
    logic last_row;
  } sts_t;

endpackage
`default_nettype wire

// ----- src/pesw_ifs.sv -----
// Valid/ready channel interfaces for path commands and edge records.
`default_nettype none
interface pesw_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [15:0] x;
  logic signed [15:0] y;
  modport source(output valid, opcode, x, y, input ready);
  modport sink(input valid, opcode, x, y, output ready);
endinterface

interface pesw_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        row;
  logic signed [12:0] xpos;
  logic              downward;
  logic              last;
  modport source(output valid, row, xpos, downward, last, input ready);
  modport sink(input valid, row, xpos, downward, last, output ready);
endinterface
`default_nettype wire

// ----- src/pesw_ctrl.sv -----
// Sequencing state machine of the edge walker.
`default_nettype none
module pesw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  input  wire pesw_pkg::sts_t sts,
  output pesw_pkg::cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MUL1  = 7'b0001000,
    S_MUL2  = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.edge_due) state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.skip ? S_IDLE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_init = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit = 1'b1;
          if (sts.last_row) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.emit | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_no_edge_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !sts.edge_due) |=> state_r == S_IDLE)
    else $error("item without edge left idle");
  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_ready) |=> state_r == S_EMIT)
    else $error("walk left emit while output stalled");
  a_last_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_row) |=> (out_valid_r && state_r == S_IDLE))
    else $error("final record not presented");

endmodule
`default_nettype wire

// ----- src/pesw_datapath.sv -----
// Figure state, slope divider, crossing accumulator and output register.
`default_nettype none
module pesw_datapath #(
  parameter int ROWS = pesw_pkg::ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pesw_pkg::cmd_t     cmd,
  output pesw_pkg::sts_t          sts,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [15:0] in_x,
  input  wire logic signed [15:0] in_y,
  input  wire logic               cfg_wr,
  input  wire logic [pesw_pkg::RC_W-1:0] cfg_wdata,
  output logic [pesw_pkg::RC_W-1:0] row_count,
  output logic [5:0]              out_row,
  output logic signed [12:0]      out_xpos,
  output logic                    out_downward,
  output logic                    out_last
);

  localparam int QW = pesw_pkg::QW;

  // figure state
  logic signed [15:0] last_px_r, last_py_r, first_px_r, first_py_r;
  logic signed [15:0] last_px_nxt, last_py_nxt, first_px_nxt, first_py_nxt;
  logic               fk_r, fo_r, fk_nxt, fo_nxt;
  logic [pesw_pkg::RC_W-1:0] row_count_r;

  // edge endpoints, top and bottom
  logic signed [15:0] tx_r, ty_r, bx_r, by_r;
  logic               down_r;
  logic signed [15:0] ex0, ey0, ex1, ey1;
  logic               sel, close_due, down_in;

  always_comb begin
    close_due = fo_r & fk_r & ((first_px_r != last_px_r) | (first_py_r != last_py_r));
    last_px_nxt  = last_px_r;
    last_py_nxt  = last_py_r;
    first_px_nxt = first_px_r;
    first_py_nxt = first_py_r;
    fk_nxt = fk_r;
    fo_nxt = fo_r;
    sel = 1'b0;
    ex0 = last_px_r;
    ey0 = last_py_r;
    ex1 = first_px_r;
    ey1 = first_py_r;
    case (pesw_pkg::op_t'(in_opcode))
      pesw_pkg::OP_MOVE: begin
        sel = close_due;
        last_px_nxt = in_x;
        last_py_nxt = in_y;
        fk_nxt = 1'b0;
        fo_nxt = 1'b1;
      end
      pesw_pkg::OP_LINE: begin
        sel = 1'b1;
        ex1 = in_x;
        ey1 = in_y;
        if (!fk_r) begin
          first_px_nxt = last_px_r;
          first_py_nxt = last_py_r;
          fk_nxt = 1'b1;
        end
        last_px_nxt = in_x;
        last_py_nxt = in_y;
      end
      pesw_pkg::OP_CLOSE: begin
        sel = close_due;
        last_px_nxt = first_px_r;
        last_py_nxt = first_py_r;
      end
      default: ;
    endcase
    down_in = ey1 > ey0;
  end

  // setup arithmetic on the latched edge
  logic signed [16:0] dx, ty3, yb5;
  logic [16:0]        dxm, dyw;
  logic signed [14:0] iy, yend, r0, r1, lim_m1;
  logic [pesw_pkg::RC_W-1:0] lim;
  logic [2:0]         dfrac;

  always_comb begin
    dx   = {bx_r[15], bx_r} - {tx_r[15], tx_r};
    dxm  = dx[16] ? 17'(-dx) : 17'(dx);
    dyw  = 17'({by_r[15], by_r} - {ty_r[15], ty_r});
    ty3  = {ty_r[15], ty_r} + 17'sd3;
    yb5  = {by_r[15], by_r} - 17'sd5;
    iy   = {ty3[16], ty3[16:3]};
    yend = {yb5[16], yb5[16:3]};
    dfrac = 3'd7 - ty3[2:0];   // distance from top point to first row centre
    lim  = (row_count_r > pesw_pkg::RC_W'(ROWS)) ? pesw_pkg::RC_W'(ROWS) : row_count_r;
    lim_m1 = $signed({{(15-pesw_pkg::RC_W){1'b0}}, lim}) - 15'sd1;
    r0   = iy[14] ? 15'sd0 : iy;
    r1   = (yend < lim_m1) ? yend : lim_m1;
  end

  // divider and walk registers
  logic [QW-1:0]      q_r;
  logic [15:0]        rem_r, dy_r;
  logic [16:0]        rem_sh;
  logic               neg_r;
  logic [4:0]         cnt_r;
  logic [2:0]         d_r;
  logic signed [14:0] iy_r, r0_r, r1_r, r_r;
  logic signed [QW:0] inv;
  logic signed [14:0] mul_b;
  logic signed [39:0] prod;
  logic signed [27:0] p1_r;
  logic signed [31:0] p2_r, p1x, acc_r, xsum;

  assign rem_sh = {rem_r, q_r[QW-1]};
  assign inv    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign mul_b  = cmd.mul1 ? $signed({12'd0, d_r}) : (r0_r - iy_r);
  assign prod   = inv * mul_b;
  assign p1x    = {{4{p1_r[27]}}, p1_r};
  assign xsum   = acc_r + 32'sd128;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_px_r  <= '0;
      last_py_r  <= '0;
      first_px_r <= '0;
      first_py_r <= '0;
      fk_r <= 1'b0;
      fo_r <= 1'b0;
      row_count_r <= pesw_pkg::ROW_COUNT_RST;
    end else begin
      if (cfg_wr) row_count_r <= cfg_wdata;
      if (cmd.accept) begin
        last_px_r  <= last_px_nxt;
        last_py_r  <= last_py_nxt;
        first_px_r <= first_px_nxt;
        first_py_r <= first_py_nxt;
        fk_r <= fk_nxt;
        fo_r <= fo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      down_r <= down_in;
      if (down_in) begin
        tx_r <= ex0; ty_r <= ey0; bx_r <= ex1; by_r <= ey1;
      end else begin
        tx_r <= ex1; ty_r <= ey1; bx_r <= ex0; by_r <= ey0;
      end
    end
    if (cmd.setup) begin
      q_r   <= {dxm[15:0], 8'd0};
      rem_r <= '0;
      dy_r  <= dyw[15:0];
      neg_r <= dx[16];
      cnt_r <= '0;
      d_r   <= dfrac;
      iy_r  <= iy;
      r0_r  <= r0;
      r1_r  <= r1;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dy_r}) begin
        rem_r <= 16'(rem_sh - {1'b0, dy_r});
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[15:0];
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.mul1) p1_r <= prod[27:0];
    if (cmd.mul2) p2_r <= prod[31:0];
    if (cmd.acc_init) begin
      acc_r <= $signed({{11{tx_r[15]}}, tx_r, 5'd0}) + (p1x >>> 3) + p2_r;
      r_r   <= r0_r;
    end else if (cmd.emit) begin
      acc_r <= acc_r + {{(31-QW){inv[QW]}}, inv};
      r_r   <= r_r + 15'sd1;
    end
    if (cmd.emit) begin
      out_row      <= r_r[5:0];
      out_xpos     <= xsum[20:8];
      out_downward <= down_r;
      out_last     <= sts.last_row;
    end
  end

  assign sts.edge_due = sel && (ey1 != ey0);
  assign sts.skip     = r0 > r1;
  assign sts.div_done = (cnt_r == 5'(QW-1));
  assign sts.last_row = (r_r == r1_r);
  assign row_count    = row_count_r;

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> ({1'b0, out_row} < lim))
    else $error("record row beyond row count");
  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < dy_r))
    else $error("divider remainder not reduced");
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_init |-> (r0_r <= r1_r))
    else $error("walk started on an empty row range");

endmodule
`default_nettype wire

// ----- src/polygon_edge_scanline_walker.sv -----
// Top level of the polygon edge scanline walker.
// Takes move/line/close path commands (points in 1/8 units) and emits one
// edge record per sample row crossed. One command is taken at a time: after
// the accept cycle, the walk runs setup, a restoring divide for the inverse
// slope, a multiply by the offset to the first row centre and one by the rows
// clipped at the top on the shared multiplier, and a step to form the start
// x, then one record per cycle while the output is not stalled. A command
// with no edge returns straight to idle, and an edge that crosses no row in
// use ends after setup. Output stalls pause the walk; the output register
// lets the next command be taken while the final record of the previous one
// still waits. row_count sits at byte address 0.
`default_nettype none
module polygon_edge_scanline_walker #(
  parameter int ROWS = pesw_pkg::ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pesw_in_if.sink   in_if,
  pesw_out_if.source out_if,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [pesw_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pesw_pkg::DATA_W-1:0] pwdata,
  output logic [pesw_pkg::DATA_W-1:0]      prdata,
  output logic      pready
);

  pesw_pkg::cmd_t cmd;
  pesw_pkg::sts_t sts;
  logic [pesw_pkg::RC_W-1:0] row_count;
  logic cfg_wr, cfg_hit;

  // register write in the access phase
  assign cfg_hit = (paddr == pesw_pkg::ADDR_ROW_COUNT);
  assign cfg_wr  = psel & penable & pwrite & cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {{(pesw_pkg::DATA_W-pesw_pkg::RC_W){1'b0}}, row_count} : '0;

  pesw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  pesw_datapath #(.ROWS(ROWS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (in_if.opcode),
    .in_x         (in_if.x),
    .in_y         (in_if.y),
    .cfg_wr       (cfg_wr),
    .cfg_wdata    (pwdata[pesw_pkg::RC_W-1:0]),
    .row_count    (row_count),
    .out_row      (out_if.row),
    .out_xpos     (out_if.xpos),
    .out_downward (out_if.downward),
    .out_last     (out_if.last)
  );

endmodule
`default_nettype wire
